// ===== sv/tof_pkg.sv =====
package tof_pkg;

    // Telnet protocol codes
    localparam logic [7:0] IAC_CODE = 8'hff;
    localparam logic [7:0] CMD_GA   = 8'd249;
    localparam logic [7:0] CMD_SB   = 8'd250;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_DONT = 8'd254;

    // Option numbers that are negotiated
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    // Result destinations
    localparam logic DEST_SERIAL = 1'b0;
    localparam logic DEST_NET    = 1'b1;

    // Input operations
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CONNECT = 1'b1;

    // Up to one reply triple per input item
    localparam int RESULTS_MAX = 3;
    localparam int CNT_W       = $clog2(RESULTS_MAX + 1);

    // Negotiation and parser state
    typedef struct packed {
        logic       in_iac;
        logic       have_command;
        logic [7:0] command_code;
        logic       server_binary;
        logic       server_echo;
        logic       server_suppress_ga;
        logic       client_binary;
        logic       client_echo;
        logic       client_suppress_ga;
    } neg_state_t;

endpackage

// ===== sv/tof_ifs.sv =====
// Network receive channel: one byte or a connect event per beat.
interface tof_rx_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] net_byte;
    logic       end_of_chunk;

    modport source (output valid, output op, output net_byte, output end_of_chunk,
                    input ready);
    modport sink   (input valid, input op, input net_byte, input end_of_chunk,
                    output ready);
endinterface

// Result channel: one serial or network byte per beat.
interface tof_tx_if;
    logic       valid;
    logic       ready;
    logic       out_dest;
    logic [7:0] out_byte;
    logic       last;
    logic       server_binary_now;

    modport source (output valid, output out_dest, output out_byte, output last,
                    output server_binary_now, input ready);
    modport sink   (input valid, input out_dest, input out_byte, input last,
                    input server_binary_now, output ready);
endinterface

// Configuration write channel for the telnet enable register.
interface tof_cfg_if;
    logic valid;
    logic ready;
    logic telnet_enable;

    modport source (output valid, output telnet_enable, input ready);
    modport sink   (input valid, input telnet_enable, output ready);
endinterface

// ===== sv/telnet_option_filter.sv =====
// Each item passes the input register and then the result group register before its first
// result beat is offered. Throughput: one item per cycle when it yields one byte or none and
// each result beat is taken when offered; an item that yields a reply triple holds the result
// group register until its three beats have gone out on the single output port.
// Reset: rst_n is asynchronous, active low; it clears the telnet enable and all negotiation state.
module telnet_option_filter (
    input  logic            clk,
    input  logic            rst_n,
    tof_rx_if.sink          rx,
    tof_tx_if.source        tx,
    tof_cfg_if.sink         cfg
);

    localparam int CW = tof_pkg::CNT_W;

    logic                    enable_reg;
    tof_pkg::neg_state_t     neg_reg;
    tof_pkg::neg_state_t     neg_next;

    logic                    in_vld_reg;
    logic                    in_op_reg;
    logic [7:0]              in_byte_reg;

    logic [CW-1:0]           grp_cnt_reg;
    logic [7:0]              grp_byte_reg [tof_pkg::RESULTS_MAX];
    logic                    grp_dest_reg;
    logic                    grp_sbin_reg;

    logic [CW-1:0]           res_cnt;
    logic                    res_dest;
    logic [7:0]              res_byte [tof_pkg::RESULTS_MAX];
    logic                    known_opt;

    logic                    rx_fire;
    logic                    tx_fire;
    logic                    grp_load;

    // Handshakes
    assign tx_fire  = tx.valid && tx.ready;
    assign grp_load = in_vld_reg &&
                      ((grp_cnt_reg == '0) || ((grp_cnt_reg == CW'(1)) && tx_fire));
    assign rx.ready = !in_vld_reg || grp_load;
    assign rx_fire  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            enable_reg <= cfg.telnet_enable;
        end
    end

    // Input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (grp_load)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_op_reg   <= rx.op;
            in_byte_reg <= rx.net_byte;
        end
    end

    // Parser and option negotiation for the item in the input register
    always_comb
    begin
        neg_next  = neg_reg;
        res_cnt   = '0;
        res_dest  = tof_pkg::DEST_SERIAL;
        res_byte[0] = in_byte_reg;
        res_byte[1] = in_byte_reg;
        res_byte[2] = in_byte_reg;
        known_opt = (in_byte_reg == tof_pkg::OPT_BINARY) ||
                    (in_byte_reg == tof_pkg::OPT_ECHO) ||
                    (in_byte_reg == tof_pkg::OPT_SGA);

        if (in_op_reg == tof_pkg::OP_CONNECT)
        begin
            neg_next = '0;
        end
        else if (!enable_reg)
        begin
            res_cnt = CW'(1);
        end
        else if (neg_reg.in_iac)
        begin
            if (neg_reg.have_command)
            begin
                // Option byte ends the sequence; unknown options after a command
                // code above SB (a negotiation verb or IAC) are refused.
                if (!known_opt && (neg_reg.command_code > tof_pkg::CMD_SB))
                begin
                    res_cnt     = CW'(3);
                    res_dest    = tof_pkg::DEST_NET;
                    res_byte[0] = tof_pkg::IAC_CODE;
                    res_byte[1] = tof_pkg::CMD_WONT;
                end
                if ((neg_reg.command_code == tof_pkg::CMD_WILL) ||
                    (neg_reg.command_code == tof_pkg::CMD_WONT))
                begin
                    if (in_byte_reg == tof_pkg::OPT_BINARY)
                    begin
                        neg_next.server_binary = (neg_reg.command_code == tof_pkg::CMD_WILL);
                    end
                    if (in_byte_reg == tof_pkg::OPT_ECHO)
                    begin
                        neg_next.server_echo = (neg_reg.command_code == tof_pkg::CMD_WILL);
                    end
                    if (in_byte_reg == tof_pkg::OPT_SGA)
                    begin
                        neg_next.server_suppress_ga =
                            (neg_reg.command_code == tof_pkg::CMD_WILL);
                    end
                end
                else if ((neg_reg.command_code == tof_pkg::CMD_DO) ||
                         (neg_reg.command_code == tof_pkg::CMD_DONT))
                begin
                    // Binary follows the request, echo is always refused and
                    // suppress-go-ahead is always accepted.
                    if (known_opt)
                    begin
                        res_cnt     = CW'(3);
                        res_dest    = tof_pkg::DEST_NET;
                        res_byte[0] = tof_pkg::IAC_CODE;
                    end
                    if (in_byte_reg == tof_pkg::OPT_BINARY)
                    begin
                        neg_next.client_binary = (neg_reg.command_code == tof_pkg::CMD_DO);
                        res_byte[1] = (neg_reg.command_code == tof_pkg::CMD_DO) ?
                                      tof_pkg::CMD_WILL : tof_pkg::CMD_WONT;
                    end
                    if (in_byte_reg == tof_pkg::OPT_ECHO)
                    begin
                        neg_next.client_echo = 1'b0;
                        res_byte[1] = tof_pkg::CMD_WONT;
                    end
                    if (in_byte_reg == tof_pkg::OPT_SGA)
                    begin
                        neg_next.client_suppress_ga = 1'b1;
                        res_byte[1] = tof_pkg::CMD_WILL;
                    end
                end
                neg_next.in_iac       = 1'b0;
                neg_next.have_command = 1'b0;
            end
            else if (in_byte_reg == tof_pkg::CMD_GA)
            begin
                neg_next.in_iac = 1'b0;
            end
            else
            begin
                neg_next.command_code = in_byte_reg;
                neg_next.have_command = 1'b1;
                // A doubled IAC is a literal data byte only in binary mode.
                if (neg_reg.server_binary && (in_byte_reg == tof_pkg::IAC_CODE))
                begin
                    neg_next.in_iac       = 1'b0;
                    neg_next.have_command = 1'b0;
                    res_cnt               = CW'(1);
                end
            end
        end
        else if (in_byte_reg == tof_pkg::IAC_CODE)
        begin
            neg_next.in_iac = 1'b1;
        end
        else
        begin
            res_cnt = CW'(1);
        end
    end

    // Negotiation state and result group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg     <= '0;
            grp_cnt_reg <= '0;
        end
        else if (grp_load)
        begin
            neg_reg     <= neg_next;
            grp_cnt_reg <= res_cnt;
        end
        else if (tx_fire)
        begin
            grp_cnt_reg <= grp_cnt_reg - CW'(1);
        end
    end

    // Result group payload; the head byte shifts out one per beat
    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            grp_byte_reg <= res_byte;
            grp_dest_reg <= res_dest;
            grp_sbin_reg <= neg_next.server_binary;
        end
        else if (tx_fire)
        begin
            for (int i = 0; i < tof_pkg::RESULTS_MAX - 1; i++)
            begin
                grp_byte_reg[i] <= grp_byte_reg[i + 1];
            end
        end
    end

    // Output channel
    assign tx.valid             = (grp_cnt_reg != '0);
    assign tx.out_dest          = grp_dest_reg;
    assign tx.out_byte          = grp_byte_reg[0];
    assign tx.last              = (grp_cnt_reg == CW'(1));
    assign tx.server_binary_now = grp_sbin_reg;

endmodule

// ===== sv/tof_checker.sv =====
module tof_checker (
    input  logic            clk,
    input  logic            rst_n,
    tof_rx_if.sink          rx,
    tof_tx_if.source        tx,
    tof_cfg_if.sink         cfg
);

    // A stalled result beat keeps its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && !tx.ready |=> tx.valid && $stable(tx.out_byte))
        else $error("stalled result beat changed");

    // Serial data bytes never come in groups.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && (tx.out_dest == tof_pkg::DEST_SERIAL) |-> tx.last)
        else $error("serial result beat not marked last");

    // Inside a reply triple the binary state shown and the destination do not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.ready && !tx.last |=>
            tx.valid && $stable(tx.server_binary_now) && $stable(tx.out_dest))
        else $error("reply triple broken up");

    // No result is offered in the cycle after reset.
    assert property (@(posedge clk)
        $past(!rst_n) |-> !tx.valid)
        else $error("result offered right after reset");

    // No result is offered while reset is active.
    assert property (@(posedge clk)
        !rst_n |-> !tx.valid)
        else $error("result offered during reset");

endmodule

bind telnet_option_filter tof_checker u_tof_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .rx    (rx),
    .tx    (tx),
    .cfg   (cfg)
);

// ===== tb/telnet_option_filter_checker.sv =====
// Watches the receive, result and configuration channels of the telnet option
// filter, predicts every result beat and compares it with what the block sends.
module telnet_option_filter_checker (
    input  logic clk,
    input  logic rst_n,
    tof_rx_if    rx,
    tof_tx_if    tx,
    tof_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    // One result beat as the block should present it.
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
        logic       sbin;
    } tx_beat_t;

    tof_pkg::neg_state_t neg;
    logic                telnet_on;
    tx_beat_t            step_beats[$];
    tx_beat_t            pending_beats[$];

    // Collects one output byte of the current input beat.
    function automatic void emit_byte(logic dest, logic [7:0] data);
        tx_beat_t t;
        t.dest = dest;
        t.data = data;
        t.last = 1'b0;
        t.sbin = 1'b0;
        if (step_beats.size() < tof_pkg::RESULTS_MAX)
            step_beats.insert(step_beats.size(), t);
    endfunction

    // A reply triple toward the network.
    function automatic void send_reply(logic [7:0] verb, logic [7:0] opt);
        emit_byte(tof_pkg::DEST_NET, tof_pkg::IAC_CODE);
        emit_byte(tof_pkg::DEST_NET, verb);
        emit_byte(tof_pkg::DEST_NET, opt);
    endfunction

    // The option byte that ends an IAC command sequence.
    function automatic void take_option(logic [7:0] c);
        logic known;
        logic is_will;
        known = (c == tof_pkg::OPT_BINARY) || (c == tof_pkg::OPT_ECHO) ||
                (c == tof_pkg::OPT_SGA);
        is_will = (neg.command_code == tof_pkg::CMD_WILL);
        if (!known && neg.command_code > tof_pkg::CMD_SB)
            send_reply(tof_pkg::CMD_WONT, c);
        if (neg.command_code == tof_pkg::CMD_WILL || neg.command_code == tof_pkg::CMD_WONT)
        begin
            if (c == tof_pkg::OPT_BINARY)
                neg.server_binary = is_will;
            if (c == tof_pkg::OPT_ECHO)
                neg.server_echo = is_will;
            if (c == tof_pkg::OPT_SGA)
                neg.server_suppress_ga = is_will;
        end
        else if (neg.command_code == tof_pkg::CMD_DO || neg.command_code == tof_pkg::CMD_DONT)
        begin
            if (c == tof_pkg::OPT_BINARY)
            begin
                if (neg.command_code == tof_pkg::CMD_DO)
                begin
                    neg.client_binary = 1'b1;
                    send_reply(tof_pkg::CMD_WILL, tof_pkg::OPT_BINARY);
                end
                else
                begin
                    neg.client_binary = 1'b0;
                    send_reply(tof_pkg::CMD_WONT, tof_pkg::OPT_BINARY);
                end
            end
            // Echo is always refused, suppress-go-ahead always accepted.
            if (c == tof_pkg::OPT_ECHO)
            begin
                neg.client_echo = 1'b0;
                send_reply(tof_pkg::CMD_WONT, tof_pkg::OPT_ECHO);
            end
            if (c == tof_pkg::OPT_SGA)
            begin
                neg.client_suppress_ga = 1'b1;
                send_reply(tof_pkg::CMD_WILL, tof_pkg::OPT_SGA);
            end
        end
        neg.in_iac = 1'b0;
        neg.have_command = 1'b0;
    endfunction

    // Advances the negotiation state by one input beat and queues its results.
    function automatic void filter_beat(logic op, logic [7:0] c);
        tx_beat_t t;
        step_beats.delete();
        if (op == tof_pkg::OP_CONNECT)
        begin
            neg = '0;
            return;
        end
        if (!telnet_on)
            emit_byte(tof_pkg::DEST_SERIAL, c);
        else if (neg.in_iac)
        begin
            if (neg.have_command)
                take_option(c);
            else if (c == tof_pkg::CMD_GA)
                neg.in_iac = 1'b0;
            else
            begin
                neg.command_code = c;
                neg.have_command = 1'b1;
                // A doubled IAC is a literal 255 only in server binary mode.
                if (neg.server_binary && c == tof_pkg::IAC_CODE)
                begin
                    neg.in_iac = 1'b0;
                    neg.have_command = 1'b0;
                    emit_byte(tof_pkg::DEST_SERIAL, tof_pkg::IAC_CODE);
                end
            end
        end
        else if (c == tof_pkg::IAC_CODE)
            neg.in_iac = 1'b1;
        else
            emit_byte(tof_pkg::DEST_SERIAL, c);
        foreach (step_beats[k])
        begin
            t = step_beats[k];
            t.last = (k == step_beats.size() - 1);
            t.sbin = neg.server_binary;
            pending_beats.insert(pending_beats.size(), t);
        end
    endfunction

    // Track configuration and input beats, and compare every result beat.
    always @(posedge clk)
    begin : watch
        tx_beat_t want;
        if (!rst_n)
        begin
            neg = '0;
            telnet_on = 1'b0;
            pending_beats.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                telnet_on = cfg.telnet_enable;
            if (rx.valid && rx.ready)
                filter_beat(rx.op, rx.net_byte);
            if (tx.valid && tx.ready)
            begin
                if (pending_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected tx beat: dest %0d byte %02h last %0d sbin %0d",
                                 tx.out_dest, tx.out_byte, tx.last, tx.server_binary_now);
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (tx.out_dest !== want.dest || tx.out_byte !== want.data ||
                        tx.last !== want.last || tx.server_binary_now !== want.sbin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("tx beat wrong: wanted dest %0d byte %02h last %0d sbin %0d",
                                     want.dest, want.data, want.last, want.sbin);
                            $display("               got dest %0d byte %02h last %0d sbin %0d",
                                     tx.out_dest, tx.out_byte, tx.last,
                                     tx.server_binary_now);
                        end
                    end
                end
            end
        end
        outstanding = pending_beats.size();
    end

endmodule

// ===== tb/telnet_option_filter_tb.sv =====
module telnet_option_filter_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   items_sent;
    int   cycles;
    int   mismatches;
    int   outstanding;

    tof_rx_if  rx();
    tof_tx_if  tx();
    tof_cfg_if cfg();

    telnet_option_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx),
        .cfg   (cfg)
    );

    telnet_option_filter_checker observer (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .tx          (tx),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 unit clock period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result receiver stalls at the rate of the current phase.
    always @(posedge clk)
        tx.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("telnet_option_filter: mismatch");
            $finish;
        end
    end

    // Sends one input beat, with random idle cycles ahead of it.
    task automatic send_beat(input logic op, input logic [7:0] b, input logic eoc);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid        <= 1'b1;
        rx.op           <= op;
        rx.net_byte     <= b;
        rx.end_of_chunk <= eoc;
        do
            @(posedge clk);
        while (!rx.ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(tof_pkg::OP_BYTE, b, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt);
        send_byte(tof_pkg::IAC_CODE);
        send_byte(cmd);
        send_byte(opt);
    endtask

    // Holds the sender until every predicted beat has arrived and the pipe is empty.
    task automatic drain();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic en);
        cfg.valid         <= 1'b1;
        cfg.telnet_enable <= en;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Mostly well-formed telnet sequences with random content, plus noise.
    task automatic send_random_run(input int target);
        int         kind;
        logic [7:0] cmd;
        logic [7:0] opt;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       cmd = tof_pkg::CMD_GA;
                1:       cmd = tof_pkg::CMD_SB;
                2:       cmd = tof_pkg::CMD_WILL;
                3:       cmd = tof_pkg::CMD_WONT;
                4:       cmd = tof_pkg::CMD_DO;
                5:       cmd = tof_pkg::CMD_DONT;
                6:       cmd = tof_pkg::IAC_CODE;
                default: cmd = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 4))
                0:       opt = tof_pkg::OPT_BINARY;
                1:       opt = tof_pkg::OPT_ECHO;
                2:       opt = tof_pkg::OPT_SGA;
                default: opt = 8'($urandom_range(0, 255));
            endcase
            if (kind < 25)
                send_byte(8'($urandom_range(0, 254)));
            else if (kind < 75)
            begin
                send_byte(tof_pkg::IAC_CODE);
                send_byte(cmd);
                if (cmd != tof_pkg::CMD_GA)
                    send_byte(opt);
            end
            else if (kind < 85)
            begin
                send_byte(tof_pkg::IAC_CODE);
                send_byte(tof_pkg::IAC_CODE);
            end
            else if (kind < 90)
                send_beat(tof_pkg::OP_CONNECT, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n             <= 1'b0;
        rx.valid          <= 1'b0;
        rx.op             <= tof_pkg::OP_BYTE;
        rx.net_byte       <= 8'h00;
        rx.end_of_chunk   <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.telnet_enable <= 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Telnet mode is off after reset, so even IAC passes through.
        send_byte(8'h00);
        send_byte(8'hff);
        drain();
        write_enable(1'b1);

        // Directed negotiation cases.
        send_byte(8'h41);
        send_byte(tof_pkg::IAC_CODE);
        send_byte(tof_pkg::CMD_GA);
        send_command(tof_pkg::IAC_CODE, 8'h05);
        send_command(tof_pkg::CMD_WILL, tof_pkg::OPT_BINARY);
        send_byte(tof_pkg::IAC_CODE);
        send_byte(tof_pkg::IAC_CODE);
        send_command(tof_pkg::CMD_DO, tof_pkg::OPT_BINARY);
        send_command(tof_pkg::CMD_DONT, tof_pkg::OPT_BINARY);
        send_command(tof_pkg::CMD_DO, tof_pkg::OPT_ECHO);
        send_command(tof_pkg::CMD_DO, tof_pkg::OPT_SGA);
        send_beat(tof_pkg::OP_CONNECT, 8'hff, 1'b1);
        drain();

        // No idling.
        send_random_run(100);
        drain();

        // Pass-through with a sender that idles half the time.
        write_enable(1'b0);
        idle_pct = 50;
        send_random_run(140);
        drain();

        // Receiver stalling half the time, with a full pause midway.
        write_enable(1'b1);
        idle_pct  = 0;
        stall_pct = 50;
        send_random_run(180);
        drain();
        send_random_run(230);
        drain();

        // Light idling on both sides.
        write_enable(1'b1);
        idle_pct  = 10;
        stall_pct = 10;
        send_random_run(270);
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("telnet_option_filter: match");
        else
            $display("telnet_option_filter: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tof_pkg.sv
sv/tof_ifs.sv
sv/telnet_option_filter.sv
sv/tof_checker.sv
tb/telnet_option_filter_checker.sv
tb/telnet_option_filter_tb.sv
